>>> rtl/core/qadd_pkg.sv
// Shared types and constants of the quantized add and requantize block.
package qadd_pkg;

  typedef enum logic {
    OP_PROCESS = 1'b0,
    OP_LOAD    = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    BCAST_SAME       = 2'd0,
    BCAST_CHAN_MAJOR = 2'd1,
    BCAST_CHAN_LAST  = 2'd2,
    BCAST_UNUSED     = 2'd3
  } bcast_t;

  typedef enum logic [2:0] {
    CFG_SIGNED_MODE    = 3'd0,
    CFG_BROADCAST_MODE = 3'd1,
    CFG_SCALE_A        = 3'd2,
    CFG_SCALE_B        = 3'd3,
    CFG_OFFSET         = 3'd4,
    CFG_CHANNEL_COUNT  = 3'd5,
    CFG_INNER_SIZE     = 3'd6,
    CFG_SPARE          = 3'd7
  } cfg_idx_t;

  localparam int ELEM_W  = 8;
  localparam int VALUE_W = 9;
  localparam int SCALE_W = 32;
  localparam int PROD_W  = VALUE_W + SCALE_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int COUNT_W = 9;
  localparam int INNER_W = 24;

  localparam int SAT_U_HI = 255;
  localparam int SAT_S_LO = -128;
  localparam int SAT_S_HI = 127;

  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = 3;
  localparam int OQ_CW    = 4;

  // Operand pair handed from the channel store stage to the arithmetic.
  typedef struct packed {
    logic              valid;
    logic [ELEM_W-1:0] a;
    logic [ELEM_W-1:0] b;
    logic              last;
  } operand_t;

  // One finished result on its way into the output queue.
  typedef struct packed {
    logic [VALUE_W-1:0] y;
    logic               last;
  } result_t;

endpackage

>>> rtl/core/qadd_front.sv
// Channel operand store, position counters and operand selection.
module qadd_front #(
  parameter int MAX_CHANNELS = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      take,
  input  qadd_pkg::opcode_t         opcode,
  input  logic [8:0]                a_value,
  input  logic [8:0]                b_value,
  input  logic [7:0]                load_channel,
  input  logic                      first_in,
  input  logic                      last_in,
  input  qadd_pkg::bcast_t          broadcast_mode,
  input  logic [8:0]                channel_count,
  input  logic [23:0]               inner_size,
  output qadd_pkg::operand_t        operand
);
  import qadd_pkg::*;

  localparam int DEPTH = (MAX_CHANNELS < 256) ? MAX_CHANNELS : 256;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [COUNT_W-1:0] CAP = COUNT_W'(DEPTH);

  logic [ELEM_W-1:0] store [DEPTH];
  logic [ELEM_W-1:0] rdata;

  logic [7:0]         channel_position;
  logic [INNER_W-1:0] inner_position;
  logic [7:0]         channel_position_next;
  logic [INNER_W-1:0] inner_position_next;

  logic [7:0]         cp_cur;
  logic [INNER_W-1:0] ip_cur;
  logic [COUNT_W-1:0] cp_inc;
  logic [INNER_W:0]   ip_inc;
  logic [7:0]         cp_wrap;
  logic [COUNT_W-1:0] count_eff;
  logic [INNER_W-1:0] inner_eff;
  logic               proc_take;
  logic               load_take;
  logic               use_store;
  logic               ch_ok;
  logic               slot_ok;

  logic               s1_valid;
  logic [ELEM_W-1:0]  s1_a;
  logic [ELEM_W-1:0]  s1_b;
  logic               s1_use_store;
  logic               s1_ch_ok;
  logic               s1_last;

  assign proc_take = take && (opcode == OP_PROCESS);
  assign load_take = take && (opcode == OP_LOAD);
  assign use_store = (broadcast_mode == BCAST_CHAN_MAJOR) ||
                     (broadcast_mode == BCAST_CHAN_LAST);

  assign cp_cur = first_in ? '0 : channel_position;
  assign ip_cur = first_in ? '0 : inner_position;
  assign ch_ok   = {1'b0, cp_cur} < CAP;
  assign slot_ok = {1'b0, load_channel} < CAP;

  always_comb begin
    count_eff = (channel_count == '0) ? COUNT_W'(1) : channel_count;
    if (count_eff > CAP) begin
      count_eff = CAP;
    end
    inner_eff = (inner_size == '0) ? INNER_W'(1) : inner_size;
    cp_inc  = {1'b0, cp_cur} + COUNT_W'(1);
    ip_inc  = {1'b0, ip_cur} + (INNER_W+1)'(1);
    cp_wrap = (cp_inc >= count_eff) ? '0 : cp_inc[7:0];
  end

  always_comb begin
    channel_position_next = cp_cur;
    inner_position_next   = ip_cur;
    unique case (broadcast_mode)
      BCAST_CHAN_MAJOR: begin
        if (ip_inc >= {1'b0, inner_eff}) begin
          inner_position_next   = '0;
          channel_position_next = cp_wrap;
        end else begin
          inner_position_next = ip_inc[INNER_W-1:0];
        end
      end
      BCAST_CHAN_LAST: begin
        channel_position_next = cp_wrap;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_position <= '0;
      inner_position   <= '0;
      s1_valid         <= 1'b0;
    end else begin
      s1_valid <= proc_take;
      if (proc_take) begin
        channel_position <= channel_position_next;
        inner_position   <= inner_position_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_take && slot_ok) begin
      store[load_channel[AW-1:0]] <= b_value[ELEM_W-1:0];
    end
    if (proc_take) begin
      rdata <= store[cp_cur[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (proc_take) begin
      s1_a         <= a_value[ELEM_W-1:0];
      s1_b         <= b_value[ELEM_W-1:0];
      s1_use_store <= use_store;
      s1_ch_ok     <= ch_ok;
      s1_last      <= last_in;
    end
  end

  always_comb begin
    operand.valid = s1_valid;
    operand.a     = s1_a;
    operand.b     = s1_use_store ? (s1_ch_ok ? rdata : '0) : s1_b;
    operand.last  = s1_last;
  end

endmodule

>>> rtl/core/qadd_datapath.sv
// Scaling multiplies, offset sum, half-to-even rounding and saturation.
module qadd_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  qadd_pkg::operand_t      operand,
  input  logic                    signed_mode,
  input  logic signed [31:0]      scale_a,
  input  logic signed [31:0]      scale_b,
  input  logic signed [31:0]      offset,
  output logic                    push,
  output qadd_pkg::result_t       result
);
  import qadd_pkg::*;

  localparam int QW = ACC_W - FRAC_BITS + 1;
  localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

  logic signed [VALUE_W-1:0] a_ext;
  logic signed [VALUE_W-1:0] b_ext;

  logic                     s2_valid;
  logic signed [PROD_W-1:0] s2_pa;
  logic signed [PROD_W-1:0] s2_pb;
  logic                     s2_last;

  logic                     s3_valid;
  logic signed [ACC_W-1:0]  s3_acc;
  logic                     s3_last;

  logic [QW-2:0]            q_floor;
  logic [FRAC_BITS-1:0]     rem;
  logic                     round_up;
  logic signed [QW-1:0]     q_round;
  logic signed [QW-1:0]     lo_w;
  logic signed [QW-1:0]     hi_w;
  logic signed [QW-1:0]     q_sat;

  assign a_ext = $signed({signed_mode & operand.a[ELEM_W-1], operand.a});
  assign b_ext = $signed({signed_mode & operand.b[ELEM_W-1], operand.b});

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s2_valid <= operand.valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_pa   <= a_ext * scale_a;
    s2_pb   <= b_ext * scale_b;
    s2_last <= operand.last;
    s3_acc  <= ACC_W'(s2_pa) + ACC_W'(s2_pb) + ACC_W'(offset);
    s3_last <= s2_last;
  end

  always_comb begin
    q_floor  = s3_acc[ACC_W-1:FRAC_BITS];
    rem      = s3_acc[FRAC_BITS-1:0];
    round_up = (rem > HALF) || ((rem == HALF) && q_floor[0]);
    q_round  = $signed({q_floor[QW-2], q_floor}) + $signed({{(QW-1){1'b0}}, round_up});
    lo_w     = signed_mode ? QW'(SAT_S_LO) : '0;
    hi_w     = signed_mode ? QW'(SAT_S_HI) : QW'(SAT_U_HI);
    q_sat    = q_round;
    if (q_round < lo_w) begin
      q_sat = lo_w;
    end
    if (q_round > hi_w) begin
      q_sat = hi_w;
    end
  end

  assign push        = s3_valid;
  assign result.y    = q_sat[VALUE_W-1:0];
  assign result.last = s3_last;

endmodule

>>> rtl/core/qadd_out_fifo.sv
// Output queue with credit count that bounds the results in flight.
module qadd_out_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic               push,
  input  qadd_pkg::result_t  push_data,
  input  logic               pop,
  output logic               room,
  output logic               not_empty,
  output qadd_pkg::result_t  head
);
  import qadd_pkg::*;

  result_t            entries [OQ_DEPTH];
  logic [OQ_AW-1:0]   wr_ptr;
  logic [OQ_AW-1:0]   rd_ptr;
  logic [OQ_CW-1:0]   fill;
  logic [OQ_CW-1:0]   credit;
  logic [OQ_CW-1:0]   fill_next;
  logic [OQ_CW-1:0]   credit_next;

  assign fill_next   = fill + OQ_CW'(push) - OQ_CW'(pop);
  assign credit_next = credit + OQ_CW'(take) - OQ_CW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
      credit <= '0;
    end else begin
      fill   <= fill_next;
      credit <= credit_next;
      if (push) begin
        wr_ptr <= wr_ptr + OQ_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OQ_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign room      = credit != OQ_CW'(OQ_DEPTH);
  assign not_empty = fill != '0;
  assign head      = entries[rd_ptr];

  a_fill_within_credit: assert property (@(posedge clk) disable iff (rst)
    fill <= credit)
    else $error("Queue holds more results than were credited.");

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit <= OQ_CW'(OQ_DEPTH))
    else $error("Credit count exceeds queue depth.");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (fill == OQ_CW'(OQ_DEPTH)) |-> !push)
    else $error("Result pushed into a full queue.");

  a_no_take_without_room: assert property (@(posedge clk) disable iff (rst)
    (credit == OQ_CW'(OQ_DEPTH)) |-> !take)
    else $error("Transaction taken with no queue space reserved.");

endmodule

>>> rtl/core/quantized_int8_add_requant.sv
// Top level of the quantized element-wise add with fixed-point requantization.
// The block takes one input transaction per clock cycle while the queue has room and
// registers each element transaction through the channel operand store read, the two
// scaling multiplies and the offset sum, with the rounding and saturation on the way
// into an eight-entry output queue.
// Input is accepted as long as the queue has a free credit, so with the output
// side always ready the sustained rate is one element per cycle; load
// transactions are accepted under the same condition and return nothing. Configuration
// writes are registered and are expected only while the block is idle.
module quantized_int8_add_requant #(
  parameter int MAX_CHANNELS = 256,
  parameter int FRAC_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // a_value[8:0], b_value[17:9], load_channel[25:18], zero
  input  logic [1:0]  s_axis_tuser,  // opcode[0], first_in[1]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // y_value[8:0], zero
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import qadd_pkg::*;

  logic               signed_mode;
  bcast_t             broadcast_mode;
  logic signed [31:0] scale_a;
  logic signed [31:0] scale_b;
  logic signed [31:0] offset;
  logic [8:0]         channel_count;
  logic [23:0]        inner_size;

  logic     cfg_write;
  logic     take;
  logic     proc_take;
  logic     room;
  logic     push;
  logic     pop;
  logic     not_empty;
  opcode_t  opcode;
  operand_t operand;
  result_t  push_data;
  result_t  head;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode    <= 1'b0;
      broadcast_mode <= BCAST_SAME;
      scale_a        <= 32'sd65536;
      scale_b        <= 32'sd65536;
      offset         <= '0;
      channel_count  <= 9'd1;
      inner_size     <= 24'd1;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SIGNED_MODE:    signed_mode    <= cfg_data[0];
        CFG_BROADCAST_MODE: broadcast_mode <= bcast_t'(cfg_data[1:0]);
        CFG_SCALE_A:        scale_a        <= $signed(cfg_data);
        CFG_SCALE_B:        scale_b        <= $signed(cfg_data);
        CFG_OFFSET:         offset         <= $signed(cfg_data);
        CFG_CHANNEL_COUNT:  channel_count  <= cfg_data[8:0];
        CFG_INNER_SIZE:     inner_size     <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

  assign opcode        = opcode_t'(s_axis_tuser[0]);
  assign s_axis_tready = room;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign proc_take     = take && (opcode == OP_PROCESS);

  qadd_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .opcode         (opcode),
    .a_value        (s_axis_tdata[8:0]),
    .b_value        (s_axis_tdata[17:9]),
    .load_channel   (s_axis_tdata[25:18]),
    .first_in       (s_axis_tuser[1]),
    .last_in        (s_axis_tlast),
    .broadcast_mode (broadcast_mode),
    .channel_count  (channel_count),
    .inner_size     (inner_size),
    .operand        (operand)
  );

  qadd_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .operand     (operand),
    .signed_mode (signed_mode),
    .scale_a     (scale_a),
    .scale_b     (scale_b),
    .offset      (offset),
    .push        (push),
    .result      (push_data)
  );

  assign pop = m_axis_tvalid && m_axis_tready;

  qadd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .take      (proc_take),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .room      (room),
    .not_empty (not_empty),
    .head      (head)
  );

  assign m_axis_tvalid = not_empty;
  assign m_axis_tdata  = {7'd0, head.y};
  assign m_axis_tlast  = head.last;

endmodule

>>> verif/quantized_int8_add_requant_test.sv
// Self-checking testbench for the quantized int8 add with requantization.
module quantized_int8_add_requant_test;
  import qadd_pkg::*;

  localparam int FRAC          = 16;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 110;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    opcode_t    op;
    logic [8:0] a;
    logic [8:0] b;
    logic [7:0] slot;
    logic       first;
    logic       last;
  } elem_cmd_t;

  typedef struct packed {
    logic [8:0] y;
    logic       last;
  } sum_rec_t;

  typedef enum logic { ROW_CMD, ROW_REG } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    cfg_idx_t    reg_idx;
    logic [31:0] reg_val;
    elem_cmd_t   cmd;
    bit          pinned;
    logic [8:0]  pin_y;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;  // a_value[8:0], b_value[17:9], load_channel[25:18], zero
  logic [1:0]  s_axis_tuser;  // opcode[0], first_in[1]
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;  // y_value[8:0], zero
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  // Shadow of the block: register copies, channel store and position counters.
  logic              r_signed;
  bcast_t            r_bcast;
  logic signed [31:0] r_scale_a;
  logic signed [31:0] r_scale_b;
  logic signed [31:0] r_offset;
  logic [8:0]        r_count;
  logic [23:0]       r_inner;
  logic [7:0]        chan_store [256];
  bit                chan_loaded [256];
  logic [7:0]        chan_pos;
  logic [23:0]       inner_pos;

  sum_rec_t  pending_sums [$];
  plan_row_t plan [$];
  elem_cmd_t seen_cmd;
  sum_rec_t  made_sum;
  sum_rec_t  got_sum;
  sum_rec_t  want_sum;
  bit        pin_on;
  logic [8:0] pin_y;

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int hold_left;
  int tensor_left;
  int cycle_count;
  int mismatches;
  int elem_count;
  int load_count;
  int checked_count;
  int reg_writes;

  quantized_int8_add_requant u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint operand_value(logic [7:0] v);
    return r_signed ? longint'($signed(v)) : longint'(v);
  endfunction

  // Applies one input transaction to the shadow state; returns 1 with the
  // requantized sum when the transaction yields a result.
  function automatic bit apply_element(elem_cmd_t c, output sum_rec_t rec);
    longint     bval;
    longint     acc;
    longint     q;
    longint     lo;
    longint     hi;
    logic [8:0] span;
    logic [8:0] cp;
    logic [24:0] ip;
    logic [23:0] inner;
    bit         per_chan;
    if (c.op == OP_LOAD) begin
      chan_store[c.slot] = c.b[7:0];
      chan_loaded[c.slot] = 1'b1;
      return 1'b0;
    end
    per_chan = (r_bcast == BCAST_CHAN_MAJOR) || (r_bcast == BCAST_CHAN_LAST);
    if (c.first) begin
      chan_pos = '0;
      inner_pos = '0;
    end
    bval = per_chan ? operand_value(chan_store[chan_pos]) : operand_value(c.b[7:0]);
    acc = operand_value(c.a[7:0]) * longint'(r_scale_a) + bval * longint'(r_scale_b)
          + longint'(r_offset);
    q = acc >>> FRAC;
    if (acc[FRAC-1:0] > (1 << (FRAC - 1)) || (acc[FRAC-1:0] == (1 << (FRAC - 1)) && q[0]))
      q = q + 1;
    lo = r_signed ? SAT_S_LO : 0;
    hi = r_signed ? SAT_S_HI : SAT_U_HI;
    if (q < lo) q = lo;
    if (q > hi) q = hi;
    rec.y = q[8:0];
    rec.last = c.last;
    span = (r_count == 9'd0) ? 9'd1 : ((r_count > 9'd256) ? 9'd256 : r_count);
    inner = (r_inner == 24'd0) ? 24'd1 : r_inner;
    cp = {1'b0, chan_pos} + 9'd1;
    if (r_bcast == BCAST_CHAN_MAJOR) begin
      ip = {1'b0, inner_pos} + 25'd1;
      if (ip >= {1'b0, inner}) begin
        inner_pos = '0;
        chan_pos = (cp >= span) ? 8'd0 : cp[7:0];
      end else begin
        inner_pos = ip[23:0];
      end
    end else if (r_bcast == BCAST_CHAN_LAST) begin
      chan_pos = (cp >= span) ? 8'd0 : cp[7:0];
    end
    return 1'b1;
  endfunction

  function automatic void plan_cmd(opcode_t op, logic [8:0] a, logic [8:0] b,
                                   logic [7:0] slot, logic first, logic last,
                                   bit pinned, logic [8:0] y);
    plan_row_t r;
    r.kind = ROW_CMD;
    r.reg_idx = CFG_SPARE;
    r.reg_val = '0;
    r.cmd = {op, a, b, slot, first, last};
    r.pinned = pinned;
    r.pin_y = y;
    plan.push_back(r);
  endfunction

  function automatic void plan_reg(cfg_idx_t idx, logic [31:0] v);
    plan_row_t r;
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = v;
    r.cmd = '0;
    r.pinned = 1'b0;
    r.pin_y = '0;
    plan.push_back(r);
  endfunction

  task automatic drive_item(elem_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, c.slot, c.b, c.a};
    s_axis_tuser <= {c.first, c.op};
    s_axis_tlast <= c.last;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SIGNED_MODE:    r_signed = v[0];
      CFG_BROADCAST_MODE: r_bcast = bcast_t'(v[1:0]);
      CFG_SCALE_A:        r_scale_a = v;
      CFG_SCALE_B:        r_scale_b = v;
      CFG_OFFSET:         r_offset = v;
      CFG_CHANNEL_COUNT:  r_count = v[8:0];
      CFG_INNER_SIZE:     r_inner = v[23:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, pending_sums.size());
      $display("quantized_int8_add_requant verification failed");
      $finish;
    end
  end

  // Results are checked before the same edge's input transaction is predicted.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_sum.y = m_axis_tdata[8:0];
      got_sum.last = m_axis_tlast;
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected result y=%h last=%b", $time, got_sum.y, got_sum.last);
        mismatches++;
      end else begin
        want_sum = pending_sums.pop_front();
        checked_count++;
        if (got_sum !== want_sum) begin
          $display("%0t: expected y=%h last=%b, got y=%h last=%b", $time,
                   want_sum.y, want_sum.last, got_sum.y, got_sum.last);
          mismatches++;
        end
      end
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      seen_cmd.op = opcode_t'(s_axis_tuser[0]);
      seen_cmd.first = s_axis_tuser[1];
      seen_cmd.a = s_axis_tdata[8:0];
      seen_cmd.b = s_axis_tdata[17:9];
      seen_cmd.slot = s_axis_tdata[25:18];
      seen_cmd.last = s_axis_tlast;
      if (apply_element(seen_cmd, made_sum)) begin
        if (pin_on) made_sum.y = pin_y;
        pending_sums.push_back(made_sum);
        elem_count++;
      end else begin
        load_count++;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    plan_row_t   row;
    elem_cmd_t   c;
    logic [31:0] sa;
    logic [31:0] sb;
    logic [31:0] off;
    logic [8:0]  cnt;
    logic [23:0] inr;
    bcast_t      bm;
    logic [7:0]  slot;
    bit          fresh;
    bit          dirty;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SPARE;
    cfg_data = '0;
    r_signed = 1'b0;
    r_bcast = BCAST_SAME;
    r_scale_a = 32'sd65536;
    r_scale_b = 32'sd65536;
    r_offset = '0;
    r_count = 9'd1;
    r_inner = 24'd1;
    chan_pos = '0;
    inner_pos = '0;
    foreach (chan_loaded[i]) chan_loaded[i] = 1'b0;
    foreach (chan_store[i]) chan_store[i] = '0;
    pin_on = 1'b0;
    pin_y = '0;
    hold_req = 1'b0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    tensor_left = 0;
    dirty = 1'b0;

    // Reset values: unsigned, same shape, unit scales.
    plan_cmd(OP_PROCESS, 9'h000, 9'h000, 8'd0, 1'b1, 1'b0, 1'b1, 9'h000);
    plan_cmd(OP_PROCESS, 9'h0FF, 9'h0FF, 8'd0, 1'b0, 1'b0, 1'b1, 9'h0FF);
    plan_cmd(OP_PROCESS, 9'h1FF, 9'h100, 8'd0, 1'b0, 1'b1, 1'b1, 9'h0FF);
    plan_reg(CFG_SIGNED_MODE, 32'd1);
    plan_cmd(OP_PROCESS, 9'h080, 9'h080, 8'd0, 1'b0, 1'b0, 1'b1, 9'h180);
    plan_cmd(OP_PROCESS, 9'h07F, 9'h07F, 8'd0, 1'b0, 1'b0, 1'b1, 9'h07F);
    // Half scale on a only: ties round to even in both signs.
    plan_reg(CFG_SCALE_A, 32'h0000_8000);
    plan_reg(CFG_SCALE_B, 32'h0000_0000);
    plan_cmd(OP_PROCESS, 9'h001, 9'h000, 8'd0, 1'b0, 1'b0, 1'b1, 9'h000);
    plan_cmd(OP_PROCESS, 9'h003, 9'h000, 8'd0, 1'b0, 1'b0, 1'b1, 9'h002);
    plan_cmd(OP_PROCESS, 9'h1FF, 9'h000, 8'd0, 1'b0, 1'b0, 1'b1, 9'h000);
    plan_cmd(OP_PROCESS, 9'h1FD, 9'h000, 8'd0, 1'b0, 1'b0, 1'b1, 9'h1FE);
    plan_reg(CFG_OFFSET, 32'h8000_0000);
    plan_cmd(OP_PROCESS, 9'h07F, 9'h000, 8'd0, 1'b0, 1'b0, 1'b1, 9'h180);
    plan_reg(CFG_OFFSET, 32'h7FFF_FFFF);
    plan_cmd(OP_PROCESS, 9'h080, 9'h000, 8'd0, 1'b0, 1'b1, 1'b1, 9'h07F);
    // Channel-last with a zero channel count, then a count above the cap.
    plan_reg(CFG_OFFSET, 32'h0000_0000);
    plan_reg(CFG_SCALE_A, 32'h0001_0000);
    plan_reg(CFG_SCALE_B, 32'h0001_0000);
    plan_reg(CFG_BROADCAST_MODE, 32'(BCAST_CHAN_LAST));
    plan_reg(CFG_CHANNEL_COUNT, 32'd0);
    plan_cmd(OP_LOAD, 9'h000, 9'h105, 8'd0, 1'b0, 1'b0, 1'b0, 9'h000);
    plan_cmd(OP_LOAD, 9'h000, 9'h0F6, 8'd1, 1'b0, 1'b0, 1'b0, 9'h000);
    plan_cmd(OP_PROCESS, 9'h000, 9'h155, 8'd0, 1'b1, 1'b0, 1'b1, 9'h005);
    plan_cmd(OP_PROCESS, 9'h001, 9'h155, 8'd0, 1'b0, 1'b0, 1'b1, 9'h006);
    plan_reg(CFG_CHANNEL_COUNT, 32'h1FF);
    plan_cmd(OP_PROCESS, 9'h000, 9'h155, 8'd0, 1'b0, 1'b0, 1'b1, 9'h005);
    plan_cmd(OP_PROCESS, 9'h000, 9'h155, 8'd0, 1'b0, 1'b0, 1'b1, 9'h1F6);
    // Channel-major with the channel counter left beyond the new count.
    plan_reg(CFG_BROADCAST_MODE, 32'(BCAST_CHAN_MAJOR));
    plan_reg(CFG_INNER_SIZE, 32'd0);
    plan_reg(CFG_CHANNEL_COUNT, 32'd2);
    plan_cmd(OP_LOAD, 9'h000, 9'h1FF, 8'd2, 1'b0, 1'b0, 1'b0, 9'h000);
    plan_cmd(OP_PROCESS, 9'h000, 9'h155, 8'd0, 1'b0, 1'b0, 1'b1, 9'h1FF);
    plan_cmd(OP_PROCESS, 9'h000, 9'h155, 8'd0, 1'b0, 1'b0, 1'b1, 9'h005);
    plan_cmd(OP_PROCESS, 9'h000, 9'h155, 8'd0, 1'b0, 1'b1, 1'b1, 9'h1F6);
    plan_reg(CFG_BROADCAST_MODE, 32'(BCAST_UNUSED));
    plan_cmd(OP_PROCESS, 9'h002, 9'h003, 8'd0, 1'b0, 1'b0, 1'b0, 9'h000);
    plan_reg(CFG_BROADCAST_MODE, 32'(BCAST_CHAN_MAJOR));
    plan_reg(CFG_INNER_SIZE, 32'd2);
    plan_cmd(OP_PROCESS, 9'h011, 9'h000, 8'd0, 1'b1, 1'b0, 1'b0, 9'h000);
    plan_cmd(OP_PROCESS, 9'h022, 9'h000, 8'd0, 1'b0, 1'b0, 1'b0, 9'h000);
    plan_cmd(OP_PROCESS, 9'h033, 9'h000, 8'd0, 1'b0, 1'b1, 1'b0, 9'h000);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_REG) begin
        if (dirty) begin
          settle();
          dirty = 1'b0;
        end
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        @(negedge clk);
        pin_on = row.pinned;
        pin_y = row.pin_y;
        drive_item(row.cmd);
        dirty = 1'b1;
      end
    end
    settle();
    pin_on = 1'b0;

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      case (p)
        0, 5, 7: bm = BCAST_CHAN_MAJOR;
        1, 3:    bm = BCAST_CHAN_LAST;
        2:       bm = BCAST_UNUSED;
        default: bm = BCAST_SAME;
      endcase
      sa = $urandom_range(262144) - 131072;
      sb = $urandom_range(262144) - 131072;
      off = $urandom_range(33554432) - 16777216;
      if ($urandom_range(1)) begin
        sa[14:0] = '0;
        sb[14:0] = '0;
        off[14:0] = '0;
      end
      cnt = 9'($urandom_range(8, 1));
      inr = 24'($urandom_range(4, 1));
      case (p)
        1: begin cnt = 9'd0; inr = 24'd0; end
        3: cnt = 9'd256;
        5: begin sa = 32'h8000_0000; sb = 32'h7FFF_FFFF; inr = 24'hFF_FFFF; end
        6: begin sa = $urandom; sb = $urandom; off = $urandom; inr = 24'($urandom); end
        7: cnt = 9'h1FF;
        default: ;
      endcase
      write_reg(CFG_SIGNED_MODE, 32'(p[0] ^ p[1]));
      write_reg(CFG_BROADCAST_MODE, 32'(bm));
      write_reg(CFG_SCALE_A, sa);
      write_reg(CFG_SCALE_B, sb);
      write_reg(CFG_OFFSET, off);
      write_reg(CFG_CHANNEL_COUNT, 32'(cnt));
      write_reg(CFG_INNER_SIZE, 32'(inr));

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        @(negedge clk);
        c.op = OP_PROCESS;
        c.a = 9'($urandom);
        c.b = 9'($urandom);
        c.slot = 8'($urandom);
        c.first = 1'($urandom);
        c.last = 1'($urandom);
        fresh = (tensor_left == 0) || ($urandom_range(99) < 3);
        slot = fresh ? 8'd0 : chan_pos;
        // A per-channel element may only read a slot that was loaded before.
        if ((r_bcast == BCAST_CHAN_MAJOR || r_bcast == BCAST_CHAN_LAST) &&
            !chan_loaded[slot]) begin
          c.op = OP_LOAD;
          c.slot = slot;
        end else if ($urandom_range(99) < 8) begin
          c.op = OP_LOAD;
        end else begin
          if (fresh) tensor_left = $urandom_range(40, 1);
          tensor_left--;
          c.first = fresh;
          c.last = (tensor_left == 0) ^ ($urandom_range(99) < 3);
        end
        drive_item(c);
        if (p == 0 && n == 30) hold_req = 1'b1;
      end
      settle();
    end

    $display("Covered %0d element and %0d channel-load transactions, %0d register writes,",
             elem_count, load_count, reg_writes);
    $display("all broadcast modes and both sign modes; %0d results checked, %0d mismatches.",
             checked_count, mismatches);
    if (mismatches == 0) begin
      $display("quantized_int8_add_requant verification clean");
    end else begin
      $display("quantized_int8_add_requant verification failed");
    end
    $finish;
  end

endmodule
